// ----- hw/rtl/scr_pkg.sv -----
// ----------------------------------------------------------------------------
// scr_pkg
// Shared constants and controller/datapath interface types for the sector
// cache clock replacement tag store.
// ----------------------------------------------------------------------------
package scr_pkg;

   localparam int ENTRIES   = 32;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int SECTOR_W  = 32;
   localparam int SLOT_W    = 5;
   localparam int RSP_DATA_W = 40;

   // Request kinds carried in req_tuser.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Commands from the controller to the datapath, at most one set per cycle.
   typedef struct packed {
      logic capture;   // latch the incoming request word
      logic hit_upd;   // mark the matching slot and send the hit result
      logic wb;        // send a write-back for the slot under the hand
      logic clr_acc;   // clear the accessed mark under the hand
      logic fill;      // retag the slot under the hand and send the miss result
   } scr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hit;
      logic hand_valid;
      logic hand_dirty;
      logic hand_acc;
      logic out_free;
   } scr_stat_type;

endpackage

// ----- hw/rtl/scr_ctrl.sv -----
// ----------------------------------------------------------------------------
// scr_ctrl
// Access sequencer: lookup; on a miss one hand step per unstalled cycle.
// ----------------------------------------------------------------------------
module scr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  scr_pkg::scr_stat_type stat,
   output scr_pkg::scr_cmd_type  cmd
);
   import scr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (stat.hit) begin
               // hold until the result register can take the word
               if (stat.out_free) begin
                  cmd.hit_upd = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stat.hand_valid || (!stat.hand_dirty && !stat.hand_acc)) begin
               if (stat.out_free) begin
                  cmd.fill = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (stat.hand_dirty) begin
               if (stat.out_free) begin
                  cmd.wb = 1'b1;
               end
            end else begin
               cmd.clr_acc = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/scr_dpath.sv -----
// ----------------------------------------------------------------------------
// scr_dpath
// Tag store, slot marks, clock hand, request latch and result register.
// ----------------------------------------------------------------------------
module scr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  scr_pkg::scr_cmd_type                cmd,
   output scr_pkg::scr_stat_type               stat,
   input  logic                                req_tuser,
   input  logic [scr_pkg::SECTOR_W-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);
   import scr_pkg::*;

   logic                op_ff;
   logic [SECTOR_W-1:0] sec_ff;
   logic [SECTOR_W-1:0] tag_ff [ENTRIES];
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic [ENTRIES-1:0]  acc_ff, acc_in;
   logic [ENTRIES-1:0]  dirty_ff, dirty_in;
   logic [IDX_W-1:0]    hand_ff, hand_in;
   logic [IDX_W-1:0]    hand_next;

   logic                ov_ff, ov_in;
   logic                owb_ff;
   logic [SLOT_W-1:0]   oslot_ff;
   logic [SECTOR_W-1:0] osec_ff;
   logic                ohit_ff;
   logic                olast_ff;

   logic [ENTRIES-1:0]  match;
   logic [IDX_W-1:0]    hit_idx;
   logic                load;
   logic [SLOT_W-1:0]   hit_ext, hand_ext;

   // fully associative compare; at most one slot can match
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (tag_ff[i] == sec_ff);
         if (match[i]) begin
            hit_idx = hit_idx | IDX_W'(i);
         end
      end
   end

   assign hand_next = (hand_ff == IDX_W'(ENTRIES - 1)) ? '0 : hand_ff + 1'b1;
   assign hit_ext   = SLOT_W'(hit_idx);
   assign hand_ext  = SLOT_W'(hand_ff);
   assign load      = cmd.hit_upd | cmd.wb | cmd.fill;

   assign stat.hit        = |match;
   assign stat.hand_valid = valid_ff[hand_ff];
   assign stat.hand_dirty = dirty_ff[hand_ff];
   assign stat.hand_acc   = acc_ff[hand_ff];
   assign stat.out_free   = !ov_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      acc_in   = acc_ff;
      dirty_in = dirty_ff;
      hand_in  = hand_ff;
      if (cmd.hit_upd) begin
         acc_in[hit_idx] = 1'b1;
         if (op_ff == OP_WRITE) begin
            dirty_in[hit_idx] = 1'b1;
         end
      end
      if (cmd.wb) begin
         dirty_in[hand_ff] = 1'b0;
         hand_in           = hand_next;
      end
      if (cmd.clr_acc) begin
         acc_in[hand_ff] = 1'b0;
         hand_in         = hand_next;
      end
      if (cmd.fill) begin
         valid_in[hand_ff] = 1'b1;
         acc_in[hand_ff]   = 1'b1;
         dirty_in[hand_ff] = (op_ff == OP_WRITE);
         hand_in           = hand_next;
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (load) begin
         ov_in = 1'b1;
      end else if (rsp_tready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         acc_ff   <= '0;
         dirty_ff <= '0;
         hand_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         acc_ff   <= acc_in;
         dirty_ff <= dirty_in;
         hand_ff  <= hand_in;
         ov_ff    <= ov_in;
      end
   end

   // payload: request latch, tags and result word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         sec_ff <= req_tdata;
      end
      if (cmd.fill) begin
         tag_ff[hand_ff] <= sec_ff;
      end
      if (cmd.hit_upd) begin
         owb_ff   <= 1'b0;
         oslot_ff <= hit_ext;
         osec_ff  <= sec_ff;
         ohit_ff  <= 1'b1;
         olast_ff <= 1'b1;
      end else if (cmd.wb) begin
         owb_ff   <= 1'b1;
         oslot_ff <= hand_ext;
         osec_ff  <= tag_ff[hand_ff];
         ohit_ff  <= 1'b0;
         olast_ff <= 1'b0;
      end else if (cmd.fill) begin
         owb_ff   <= 1'b0;
         oslot_ff <= hand_ext;
         osec_ff  <= sec_ff;
         ohit_ff  <= 1'b0;
         olast_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - SECTOR_W){1'b0}}, osec_ff, oslot_ff};
   assign rsp_tuser  = {ohit_ff, owb_ff};
   assign rsp_tlast  = olast_ff;

endmodule

// ----- hw/rtl/sector_cache_clock_replacement.sv -----
// ----------------------------------------------------------------------------
// sector_cache_clock_replacement
// Fully associative sector cache tag store with clock replacement.
// ----------------------------------------------------------------------------
// Each request word is a read or write access to one sector. A hit is a
// latch, then a compare against all 32 tags in parallel, and returns one
// word with hit set. A miss then walks the clock hand one slot per cycle
// while no write-back or fill waits on rsp_tready: a dirty slot sends a write-back
// word and loses its dirty mark, an accessed slot loses its accessed mark,
// and the first empty or clean unaccessed slot is retagged and reported
// with hit clear. On a miss the hand covers at most three turns of the ring,
// and a result word may be held in the result register by rsp_tready.
// Requests are taken one at a time; the last result word marked by rsp_tlast
// may still wait in the result register while the next request is taken.
module sector_cache_clock_replacement (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [scr_pkg::SECTOR_W-1:0]        req_tdata,  // [31:0] sector
   input  logic                                req_tuser,  // [0] opcode (1 = write)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scr_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [4:0] slot, [36:5] target_sector
   output logic [1:0]                          rsp_tuser,  // [0] is_writeback, [1] hit
   output logic                                rsp_tlast
);
   import scr_pkg::*;

   scr_cmd_type  cmd;
   scr_stat_type stat;

   scr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   scr_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
